/* hdl/key_value_table_macros.svh */
// Assertion helpers for the key/value table.
// Both forms assume a clock clk_i and an active-low reset rst_ni in scope.
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KVT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KVT_ASSERT(lbl, expr, msg)
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/kvt_pkg.sv */
package kvt_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 32;

  // fixed port field widths
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = KEY_W + VALUE_W;
  localparam int OUT_DATA_W = KEY_W + VALUE_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_ERASE     = 3'd1,
    ACT_FIND_KEY  = 3'd2,
    ACT_FIND_VAL  = 3'd3,
    ACT_UPDATE    = 3'd4
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  // per-cell control for one cycle
  typedef struct packed {
    logic shift;      // take the neighbor's entry
    logic take_head;  // this cell is the chain tail: take the head entry instead
    logic load;       // write the entry being inserted
  } cell_ctrl_t;

endpackage

/* hdl/kvt_cell.sv */
module kvt_cell
  import kvt_pkg::*;
#(
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [VALUE_BITS-1:0] next_val_i,
  input  logic [KEY_BITS-1:0]   head_key_i,
  input  logic [VALUE_BITS-1:0] head_val_i,
  input  logic [KEY_BITS-1:0]   ins_key_i,
  input  logic [VALUE_BITS-1:0] ins_val_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] val_o
);

  logic [KEY_BITS-1:0]   key_d, key_q;
  logic [VALUE_BITS-1:0] val_d, val_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    priority if (ctrl_i.load) begin
      key_d = ins_key_i;
      val_d = ins_val_i;
    end else if (ctrl_i.shift && ctrl_i.take_head) begin
      key_d = head_key_i;
      val_d = head_val_i;
    end else if (ctrl_i.shift) begin
      key_d = next_key_i;
      val_d = next_val_i;
    end else begin
      key_d = key_q;
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;

endmodule

/* hdl/key_value_table.sv */
// Ordered key/value table built as a chain of entry cells. Entries live in
// insertion order; every action walks the table by rotating the live entries
// one cell per cycle past the head cell (a find-by-value match waiting on a
// stalled result port pauses the walk), so order is restored at the end and
// an erase simply drops the head entry from the ring. An item with a valid
// action is taken, steps once per stored entry, then posts its final result,
// later if the result port stalls. Find by value posts one result per match,
// the last one flagged by tlast, or a single not-found result. Items with an
// undefined action code are taken and give no result. A new item is taken
// once the previous item's final result sits in the output register.
`include "key_value_table_macros.svh"

module key_value_table
  import kvt_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key[63:0], value[95:64]
  input  logic [ACTION_W-1:0]   s_axis_tuser,   // action[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // found_key[63:0], found_value[95:64]
  output logic [STATUS_W-1:0]   m_axis_tuser,   // status[1:0]
  output logic                  m_axis_tlast    // last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_e                state_d, state_q;
  act_e                  act_d, act_q;
  logic [KEY_BITS-1:0]   key_d, key_q;
  logic [VALUE_BITS-1:0] val_d, val_q;
  logic [CNT_W-1:0]      count_d, count_q;
  logic [CNT_W-1:0]      len_d, len_q;
  logic [CNT_W-1:0]      rem_d, rem_q;
  logic                  found_d, found_q;
  logic [VALUE_BITS-1:0] fv_d, fv_q;
  logic                  pend_d, pend_q;
  logic [KEY_BITS-1:0]   pend_key_d, pend_key_q;

  logic                  out_valid_d, out_valid_q;
  status_e               out_status_d, out_status_q;
  logic [KEY_BITS-1:0]   out_key_d, out_key_q;
  logic [VALUE_BITS-1:0] out_val_d, out_val_q;
  logic                  out_last_d, out_last_q;

  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_ctrl_t            cell_ctrl [CAPACITY];
  logic [VALUE_BITS-1:0] head_val_wr;

  logic [KEY_W-1:0]      in_key;
  logic [KEY_W-1:0]      in_val_ext;
  logic                  in_take;
  logic                  in_act_ok;
  logic                  slot_free;
  logic                  hit_key, hit_val;
  logic                  scanning, need_emit, step_go, drop;
  logic                  final_step, fin_go, ins_ok, ins_fin;
  logic                  emit;

  assign in_key     = s_axis_tdata[KEY_W-1:0];
  assign in_val_ext = KEY_W'(signed'(s_axis_tdata[IN_DATA_W-1:KEY_W]));
  assign in_act_ok  = s_axis_tuser <= ACT_UPDATE;

  assign s_axis_tready = state_q == S_IDLE;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  assign hit_key = cell_key[0] == key_q;
  assign hit_val = cell_val[0] == val_q;

  assign scanning   = (state_q == S_SCAN) && (rem_q != '0);
  assign need_emit  = (act_q == ACT_FIND_VAL) && hit_val && pend_q;
  assign step_go    = scanning && (!need_emit || slot_free);
  assign drop       = (act_q == ACT_ERASE) && hit_key;
  assign final_step = (state_q == S_SCAN) && (rem_q == '0);
  assign fin_go     = final_step && slot_free;
  assign ins_ok     = (act_q == ACT_INSERT) && !found_q && (count_q != CNT_W'(CAPACITY));
  assign ins_fin    = fin_go && ins_ok;

  // update rewrites the value as the entry passes from head to tail
  assign head_val_wr = ((act_q == ACT_UPDATE) && hit_key) ? val_q : cell_val[0];

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_BITS-1:0]   nkey;
    logic [VALUE_BITS-1:0] nval;

    if (j == CAPACITY - 1) begin : g_end
      assign nkey = cell_key[0];
      assign nval = head_val_wr;
    end else begin : g_mid
      assign nkey = cell_key[j+1];
      assign nval = cell_val[j+1];
    end

    assign cell_ctrl[j].shift     = step_go;
    assign cell_ctrl[j].take_head = !drop && (len_q == CNT_W'(j + 1));
    assign cell_ctrl[j].load      = ins_fin && (count_q == CNT_W'(j));

    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[j]),
      .next_key_i (nkey),
      .next_val_i (nval),
      .head_key_i (cell_key[0]),
      .head_val_i (head_val_wr),
      .ins_key_i  (key_q),
      .ins_val_i  (val_q),
      .key_o      (cell_key[j]),
      .val_o      (cell_val[j])
    );
  end

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    key_d        = key_q;
    val_d        = val_q;
    count_d      = count_q;
    len_d        = len_q;
    rem_d        = rem_q;
    found_d      = found_q;
    fv_d         = fv_q;
    pend_d       = pend_q;
    pend_key_d   = pend_key_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_val_d    = out_val_q;
    out_last_d   = out_last_q;
    emit         = 1'b0;

    if (in_take && in_act_ok) begin
      state_d = S_SCAN;
      act_d   = act_e'(s_axis_tuser);
      key_d   = in_key[KEY_BITS-1:0];
      val_d   = in_val_ext[VALUE_BITS-1:0];
      rem_d   = count_q;
      len_d   = count_q;
      found_d = 1'b0;
      pend_d  = 1'b0;
    end

    if (step_go) begin
      rem_d = rem_q - CNT_W'(1);
      if (act_q == ACT_FIND_VAL) begin
        if (hit_val) begin
          pend_d     = 1'b1;
          pend_key_d = cell_key[0];
        end
        if (need_emit) begin
          emit         = 1'b1;
          out_status_d = ST_OK;
          out_key_d    = pend_key_q;
          out_val_d    = '0;
          out_last_d   = 1'b0;
        end
      end else if (hit_key) begin
        found_d = 1'b1;
        fv_d    = cell_val[0];
        if (drop) len_d = len_q - CNT_W'(1);
      end
    end

    if (fin_go) begin
      state_d    = S_IDLE;
      emit       = 1'b1;
      out_key_d  = '0;
      out_val_d  = '0;
      out_last_d = 1'b1;
      unique case (act_q)
        ACT_INSERT: begin
          priority if (found_q) out_status_d = ST_DUP;
          else if (!ins_ok)     out_status_d = ST_FULL;
          else begin
            out_status_d = ST_OK;
            count_d      = count_q + CNT_W'(1);
          end
        end
        ACT_FIND_VAL: begin
          out_status_d = pend_q ? ST_OK : ST_MISSING;
          out_key_d    = pend_q ? pend_key_q : '0;
        end
        ACT_FIND_KEY: begin
          out_status_d = found_q ? ST_OK : ST_MISSING;
          out_val_d    = found_q ? fv_q : '0;
        end
        ACT_ERASE: begin
          out_status_d = found_q ? ST_OK : ST_MISSING;
          count_d      = len_q;
        end
        default: begin
          out_status_d = found_q ? ST_OK : ST_MISSING;
        end
      endcase
    end

    out_valid_d = emit || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_INSERT;
      count_q     <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      count_q     <= count_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    val_q        <= val_d;
    fv_q         <= fv_d;
    pend_key_q   <= pend_key_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_val_q    <= out_val_d;
    out_last_q   <= out_last_d;
  end

  // stored values narrower than the port are zero-filled, as the table masks them
  logic [VALUE_W-1:0] out_val_port;
  if (VALUE_BITS >= VALUE_W) begin : g_val_cut
    assign out_val_port = out_val_q[VALUE_W-1:0];
  end else begin : g_val_ext
    assign out_val_port = VALUE_W'(out_val_q);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_val_port, KEY_W'(out_key_q)};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  `KVT_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `KVT_ASSERT(a_len_le_count, len_q <= count_q, "ring length above entry count")
  `KVT_ASSERT(a_idle_no_rem, (state_q != S_IDLE) || (rem_q == '0), "scan left unfinished")
  `KVT_ASSERT_NEXT(a_insert_grows, ins_fin, count_q == $past(count_q) + CNT_W'(1), "insert lost")
  `KVT_ASSERT_NEXT(a_emit_shows, emit, m_axis_tvalid, "result lost")

endmodule
